[sv/med_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// med_pkg
// shared types and constants for the multilevel error diffusion block
// ----------------------------------------------------------------------------
package med_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS             = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RIGHT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BELOW_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BELOW       = 3'd6;

    // register reset values
    localparam logic [12:0] RST_WIDTH_PIXELS       = 13'd640;
    localparam logic [15:0] RST_HEIGHT_ROWS        = 16'd480;
    localparam logic [2:0]  RST_BYTES_PER_PIXEL    = 3'd1;
    localparam logic [7:0]  RST_LEVELS             = 8'd1;
    localparam logic [7:0]  RST_WEIGHT_RIGHT       = 8'd7;
    localparam logic [7:0]  RST_WEIGHT_BELOW_RIGHT = 8'd1;
    localparam logic [7:0]  RST_WEIGHT_BELOW       = 8'd5;

    localparam logic [7:0] BYTE_MAX = 8'hFF;
    localparam logic [2:0] MAX_CHANNELS = 3'd4;

    // shared divider
    localparam int DVD_W  = 16;
    localparam int DVS_W  = 10;
    localparam int ITER_W = 5;

    localparam logic [ITER_W-1:0] STEP_ITERS  = 5'd8;
    localparam logic [ITER_W-1:0] MOD_ITERS   = 5'd9;
    localparam logic [ITER_W-1:0] SHARE_ITERS = 5'd16;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_STEP = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_SR   = 7'b0001000,
        S_SBR  = 7'b0010000,
        S_SB   = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

endpackage

[sv/multilevel_error_diffusion.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_error_diffusion
// multilevel error diffusion dither for an interleaved raster byte stream
// ----------------------------------------------------------------------------
// Each input byte is quantised to a multiple of the step 255/levels after the
// error accumulated at its position is added, and its remainder is shared to
// the right, lower-right and lower neighbours of the same channel. The block
// takes one byte at a time. Its pace is set by the single shared divider,
// which makes one quotient bit per cycle and is used five times per byte
// (step 8 bits, remainder 9 bits, three shares of 16 bits each), or twice
// when all three weights are zero. A result waits in the output register,
// so the next byte is taken while it is still pending. The line memory
// needs no clearing pass: the first row of a frame ignores its contents.
// Writing width, height or bytes per pixel restarts the frame. The user
// must write configuration only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module multilevel_error_diffusion #(
    parameter int MAX_ROW_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel_byte
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] dithered_byte
    output logic                           m_tlast,   // frame_end
    // configuration writes
    input  logic                           cfg_we,
    input  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [med_pkg::CFG_DATA_W-1:0] cfg_data
);
    import med_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int ROW_W  = $clog2(MAX_ROW_BYTES + 1);

    // configuration registers
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  bpp_reg;
    logic [7:0]  levels_reg;
    logic [7:0]  wr_reg;
    logic [7:0]  wbr_reg;
    logic [7:0]  wb_reg;

    // effective geometry and weights
    logic [12:0]      w_eff;
    logic [15:0]      h_eff;
    logic [2:0]       ps_eff;
    logic [7:0]       rank_eff;
    logic [DVS_W-1:0] wsum;
    logic [15:0]      row_prod;
    logic [ROW_W-1:0] row_bytes;

    // position in the frame
    logic [ADDR_W-1:0] col_reg;
    logic [1:0]        ch_reg;
    logic [15:0]       row_reg;
    logic              col_stray;
    logic [ADDR_W-1:0] j_eff;
    logic [1:0]        ch_eff;

    // per-item working registers
    state_t            state_reg;
    logic [7:0]        pixel_reg;
    logic [ADDR_W-1:0] j_reg;
    logic [1:0]        chan_reg;
    logic [7:0]        line_rd_reg;
    logic [8:0]        sum_reg;
    logic [7:0]        err_reg;
    logic [7:0]        q_reg;
    logic [7:0]        sr_reg;
    logic [7:0]        sbr_reg;
    logic [7:0]        sb_reg;

    // pending shares per channel
    logic [7:0] right_err_reg [MAX_CHANNELS];
    logic [7:0] brh_reg       [MAX_CHANNELS];

    // line memory of errors for the next row
    logic [7:0] line_mem [MAX_ROW_BYTES];

    // output register
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    // shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic             accept;
    logic             commit;
    logic             geom_write;
    logic [7:0]       acc;
    logic [8:0]       sum_next;
    logic [7:0]       err_now;
    logic [8:0]       q_full;
    logic [7:0]       q_sat;
    logic [7:0]       mul_a;
    logic [7:0]       mul_b;
    logic [15:0]      prod;
    logic [ROW_W:0]   j_plus_ps;
    logic [ROW_W:0]   j_plus_1;
    logic             has_right;
    logic             has_below;
    logic             row_end;
    logic             last_row;
    logic             frame_done;
    logic [7:0]       mem_wdata;
    logic [1:0]       ch_next;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        geom_write = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index) inside
                REG_WIDTH_PIXELS, REG_HEIGHT_ROWS, REG_BYTES_PER_PIXEL:
                    geom_write = 1'b1;
                default:
                    geom_write = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH_PIXELS;
            height_reg <= RST_HEIGHT_ROWS;
            bpp_reg    <= RST_BYTES_PER_PIXEL;
            levels_reg <= RST_LEVELS;
            wr_reg     <= RST_WEIGHT_RIGHT;
            wbr_reg    <= RST_WEIGHT_BELOW_RIGHT;
            wb_reg     <= RST_WEIGHT_BELOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH_PIXELS:       width_reg  <= cfg_data[12:0];
                REG_HEIGHT_ROWS:        height_reg <= cfg_data[15:0];
                REG_BYTES_PER_PIXEL:    bpp_reg    <= cfg_data[2:0];
                REG_LEVELS:             levels_reg <= cfg_data[7:0];
                REG_WEIGHT_RIGHT:       wr_reg     <= cfg_data[7:0];
                REG_WEIGHT_BELOW_RIGHT: wbr_reg    <= cfg_data[7:0];
                REG_WEIGHT_BELOW:       wb_reg     <= cfg_data[7:0];
                default:                ;   // unused index, ignored
            endcase
        end
    end

    // zero geometry acts as one, more than four channels acts as four
    assign w_eff    = (width_reg == '0) ? 13'd1 : width_reg;
    assign h_eff    = (height_reg == '0) ? 16'd1 : height_reg;
    assign ps_eff   = (bpp_reg == '0) ? 3'd1 :
                      ((bpp_reg > MAX_CHANNELS) ? MAX_CHANNELS : bpp_reg);
    assign rank_eff = (levels_reg == '0) ? 8'd1 : levels_reg;
    assign wsum     = {2'b00, wr_reg} + {2'b00, wbr_reg} + {2'b00, wb_reg};

    // row length in bytes, clamped to the line memory
    assign row_prod  = 16'(w_eff) * 16'(ps_eff);
    assign row_bytes = (32'(row_prod) > 32'(MAX_ROW_BYTES)) ?
                       ROW_W'(MAX_ROW_BYTES) : ROW_W'(row_prod);

    // a column beyond the row length restarts at zero
    assign col_stray = (ROW_W'(col_reg) >= row_bytes);
    assign j_eff     = col_stray ? '0 : col_reg;
    assign ch_eff    = col_stray ? 2'd0 : ch_reg;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // datapath around the divider
    // ------------------------------------------------------------------
    // the first row of a frame sees no errors from above
    assign acc      = ((row_reg == '0) ? 8'd0 : line_rd_reg) + right_err_reg[chan_reg];
    assign sum_next = {1'b0, pixel_reg} + {1'b0, acc};

    assign err_now = div_rsp.remainder[7:0];
    assign q_full  = sum_reg - {1'b0, err_now};
    assign q_sat   = q_full[8] ? BYTE_MAX : q_full[7:0];

    // one multiplier, feeding the divider's dividend register
    always_comb
    begin
        mul_a = err_reg;
        mul_b = wb_reg;
        case (state_reg)
            S_MOD:
            begin
                mul_a = err_now;
                mul_b = wr_reg;
            end
            S_SR:    mul_b = wbr_reg;
            default: mul_b = wb_reg;
        endcase
    end

    assign prod = 16'(mul_a) * 16'(mul_b);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.iters    = SHARE_ITERS;
        div_req.dividend = prod;
        div_req.divisor  = wsum;
        unique case (state_reg)
            S_IDLE:
            begin
                // step = 255 / rank
                div_req.start    = accept;
                div_req.iters    = STEP_ITERS;
                div_req.dividend = {BYTE_MAX, 8'd0};
                div_req.divisor  = {2'b00, rank_eff};
            end
            S_STEP:
            begin
                // error = sum mod step
                div_req.start    = div_rsp.done;
                div_req.iters    = MOD_ITERS;
                div_req.dividend = {sum_next, 7'd0};
                div_req.divisor  = {2'b00, div_rsp.quotient[7:0]};
            end
            S_MOD:   div_req.start = div_rsp.done && (wsum != '0);
            S_SR:    div_req.start = div_rsp.done;
            S_SBR:   div_req.start = div_rsp.done;
            S_SB:    div_req.start = 1'b0;
            S_DONE:  div_req.start = 1'b0;
            default: div_req.start = 1'b0;
        endcase
    end

    med_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // neighbour tests and row bookkeeping
    // ------------------------------------------------------------------
    assign j_plus_ps  = (ROW_W+1)'(j_reg) + (ROW_W+1)'(ps_eff);
    assign j_plus_1   = (ROW_W+1)'(j_reg) + (ROW_W+1)'(1);
    assign has_right  = (j_plus_ps < (ROW_W+1)'(row_bytes));
    assign row_end    = (j_plus_1 >= (ROW_W+1)'(row_bytes));
    assign last_row   = (({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff});
    assign has_below  = !last_row;
    assign frame_done = row_end && last_row;

    // below share plus the lower-right share held from the previous pixel
    assign mem_wdata = (has_below ? sb_reg : 8'd0) + brh_reg[chan_reg];

    assign ch_next = ({1'b0, chan_reg} == (ps_eff - 3'd1)) ? 2'd0 : (chan_reg + 2'd1);

    // ------------------------------------------------------------------
    // sequencer and stream state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            ch_reg       <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < int'(MAX_CHANNELS); i++)
            begin
                right_err_reg[i] <= '0;
                brh_reg[i]       <= '0;
            end
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= (wsum != '0) ? S_SR : S_DONE;
                    end
                end
                S_SR:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_SBR;
                    end
                end
                S_SBR:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_SB;
                    end
                end
                S_SB:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b1;
                        right_err_reg[chan_reg] <= has_right ? sr_reg : 8'd0;
                        brh_reg[chan_reg] <= (has_right && has_below) ? sbr_reg : 8'd0;
                        if (row_end)
                        begin
                            col_reg <= '0;
                            ch_reg  <= '0;
                            row_reg <= row_reg + 16'd1;
                        end
                        else
                        begin
                            col_reg <= ADDR_W'(j_plus_1);
                            ch_reg  <= ch_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // end of frame or new geometry: start the stream afresh
            if ((commit && frame_done) || geom_write)
            begin
                col_reg <= '0;
                ch_reg  <= '0;
                row_reg <= '0;
                for (int i = 0; i < int'(MAX_CHANNELS); i++)
                begin
                    right_err_reg[i] <= '0;
                    brh_reg[i]       <= '0;
                end
            end
        end
    end

    // per-item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg <= s_tdata;
            j_reg     <= j_eff;
            chan_reg  <= ch_eff;
        end
        if ((state_reg == S_STEP) && div_rsp.done)
        begin
            sum_reg <= sum_next;
        end
        if ((state_reg == S_MOD) && div_rsp.done)
        begin
            err_reg <= err_now;
            q_reg   <= q_sat;
            sr_reg  <= '0;
            sbr_reg <= '0;
            sb_reg  <= '0;
        end
        if ((state_reg == S_SR) && div_rsp.done)
        begin
            sr_reg <= div_rsp.quotient[7:0];
        end
        if ((state_reg == S_SBR) && div_rsp.done)
        begin
            sbr_reg <= div_rsp.quotient[7:0];
        end
        if ((state_reg == S_SB) && div_rsp.done)
        begin
            sb_reg <= div_rsp.quotient[7:0];
        end
        if (commit)
        begin
            m_tdata_reg <= q_reg;
            m_tlast_reg <= frame_done;
        end
    end

    // line memory: read on the transfer, written when the item completes
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            line_mem[j_reg] <= mem_wdata;
        end
        if (accept)
        begin
            line_rd_reg <= line_mem[j_eff];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // one byte at a time: no transfer directly after a transfer
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a byte is in progress");

    // divider results arrive only while the sequencer waits for them
    a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_STEP || state_reg == S_MOD ||
                          state_reg == S_SR || state_reg == S_SBR ||
                          state_reg == S_SB))
        else $error("divider finished outside a waiting state");

    // column counter never leaves the row
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ROW_W'(col_reg) < row_bytes)
        else $error("column beyond row length");

    // a completed item always presents a result
    a_commit_output: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (m_tvalid && state_reg == S_IDLE))
        else $error("completed item did not reach the output register");

endmodule

[sv/med_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// med_div
// restoring divider, one quotient bit per cycle, variable iteration count
// ----------------------------------------------------------------------------
module med_div (
    input  logic              clk,
    input  logic              rst_n,
    input  med_pkg::div_req_t req,
    output med_pkg::div_rsp_t rsp
);
    import med_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    partial;
    logic [DVS_W+1:0]  diff;
    logic              fits;
    logic [DVS_W-1:0]  rem_next;

    // dividend is loaded left aligned, quotient bits enter at the bottom
    assign partial  = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff     = {1'b0, partial} - {2'b00, dvs_reg};
    assign fits     = ~diff[DVS_W+1];
    assign rem_next = fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule
